### design/ptp_port_state_controller_unit_assert.svh
// assertion macros for the port state controller checker
`ifndef PTP_PORT_STATE_CONTROLLER_UNIT_ASSERT_SVH
`define PTP_PORT_STATE_CONTROLLER_UNIT_ASSERT_SVH
// immediate implication checked every clock outside reset
`define PSC_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
// next-cycle implication checked every clock outside reset
`define PSC_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`endif

### design/psc_pkg.sv
// shared types, codes and arithmetic helpers of the port state controller
`default_nettype none
package psc_pkg;
   localparam int TIME_W = 63;
   localparam logic [TIME_W-1:0] TIME_MAX = {TIME_W{1'b1}};
   localparam logic [63:0] NS_PER_S = 64'd1000000000;
   localparam logic [63:0] US_PER_S = 64'd1000000;
   localparam logic [63:0] WAKE_SPAN_NS = 64'd120000000000;

   localparam logic [3:0] ST_INIT = 4'd0;
   localparam logic [3:0] ST_FAULTY = 4'd1;
   localparam logic [3:0] ST_DISABLED = 4'd2;
   localparam logic [3:0] ST_LISTENING = 4'd3;
   localparam logic [3:0] ST_PREMASTER = 4'd4;
   localparam logic [3:0] ST_MASTER = 4'd5;
   localparam logic [3:0] ST_PASSIVE = 4'd6;
   localparam logic [3:0] ST_UNCAL = 4'd7;
   localparam logic [3:0] ST_SLAVE = 4'd8;

   localparam logic [1:0] CMD_TICK = 2'd0;
   localparam logic [1:0] CMD_BMC = 2'd1;
   localparam logic [1:0] CMD_CHECK = 2'd2;

   localparam logic [2:0] REC_M3 = 3'd2;
   localparam logic [2:0] REC_P2 = 3'd4;
   localparam logic [2:0] REC_S1 = 3'd5;

   localparam logic [1:0] REG_LOG_ANN = 2'd0;
   localparam logic [1:0] REG_LOG_SYNC = 2'd1;
   localparam logic [1:0] REG_LOG_DREQ = 2'd2;
   localparam logic [1:0] REG_RCPT_CNT = 2'd3;

   localparam int TMR_ANN = 0;
   localparam int TMR_SYNC = 1;
   localparam int TMR_DREQ = 2;
   localparam int TMR_RCPT = 3;

   typedef struct packed {
      logic [1:0] command;
      logic [62:0] now_ns;
      logic [2:0] recommendation;
      logic [63:0] master_identity;
      logic [15:0] hop_count;
      logic sends_accepted;
      logic [27:0] random_delay_us;
      logic random_extra_window;
   } req_type;

   typedef struct packed {
      logic [3:0] port_state_now;
      logic send_sync;
      logic send_announce;
      logic send_delay_req;
      logic [15:0] message_sequence;
      logic [15:0] announce_sequence;
      logic [62:0] next_wakeup_ns;
      logic bmc_changed;
      logic receipt_expired;
   } rsp_type;

   typedef struct packed {
      logic [3:0] log_ann;
      logic [3:0] log_sync;
      logic [3:0] log_dreq;
      logic [7:0] rcpt_cnt;
   } cfg_type;

   // 2^lg seconds in ns, lg a 5-bit signed code in -8..8
   function automatic logic [63:0] interval_ns(input logic signed [4:0] lg);
      logic [3:0] sh;
      begin
         sh = lg[4] ? 4'(-lg) : lg[3:0];
         interval_ns = lg[4] ? (NS_PER_S >> sh) : (NS_PER_S << sh);
      end
   endfunction

   // 2^lg seconds in whole us, same rounding as the ns interval divided by 1000
   function automatic logic [63:0] interval_us(input logic signed [4:0] lg);
      logic [3:0] sh;
      begin
         sh = lg[4] ? 4'(-lg) : lg[3:0];
         interval_us = lg[4] ? (US_PER_S >> sh) : (US_PER_S << sh);
      end
   endfunction

   function automatic logic [62:0] sat_add(input logic [62:0] a, input logic [62:0] b);
      logic [63:0] s;
      begin
         s = {1'b0, a} + {1'b0, b};
         sat_add = s[63] ? TIME_MAX : s[62:0];
      end
   endfunction

   // product clipped to 63 bits with saturation
   function automatic logic [62:0] sat63(input logic [95:0] v);
      sat63 = (|v[95:63]) ? TIME_MAX : v[62:0];
   endfunction
endpackage
`default_nettype wire

### design/psc_if.sv
// valid/ready channel interfaces of the port state controller
`default_nettype none
interface psc_req_if import psc_pkg::*; ();
   logic valid;
   logic ready;
   req_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface psc_rsp_if import psc_pkg::*; ();
   logic valid;
   logic ready;
   rsp_type data;
   modport source (output valid, output data, input ready);
   modport sink (input valid, input data, output ready);
endinterface

interface psc_csr_if ();
   logic valid;
   logic ready;
   logic [1:0] index;
   logic [7:0] wdata;
   modport source (output valid, output index, output wdata, input ready);
   modport sink (input valid, input index, input wdata, output ready);
endinterface
`default_nettype wire

### design/psc_intervals.sv
// interval products derived from the configuration registers
`default_nettype none
module psc_intervals import psc_pkg::*; (
   input wire logic clock,
   input wire cfg_type cfg,
   output logic [62:0] ann_ns,
   output logic [62:0] sync_ns,
   output logic [62:0] rcpt_base_ns,
   output logic [62:0] rcpt_ext_ns,
   output logic [27:0] dreq_lo_us,
   output logic [27:0] dreq_hi_us
);
   // registered; user keeps config changes to idle, not enforced here
   logic [62:0] ann_ns_ff, sync_ns_ff, rb_ff, re_ff;
   logic [27:0] lo_ff, hi_ff;
   logic [63:0] ann64, sync64, dlo, dhi;
   logic signed [4:0] ldq;

   always_comb begin
      ann64 = interval_ns({cfg.log_ann[3], cfg.log_ann});
      sync64 = interval_ns({cfg.log_sync[3], cfg.log_sync});
      ldq = {cfg.log_dreq[3], cfg.log_dreq};
      dlo = interval_us(ldq);
      dhi = interval_us(ldq + 5'sd1);
   end

   always_ff @(posedge clock) begin
      ann_ns_ff <= ann64[62:0];
      sync_ns_ff <= sync64[62:0];
      rb_ff <= sat63(96'(ann64) * 96'(cfg.rcpt_cnt));
      re_ff <= sat63(96'(ann64) * (96'(cfg.rcpt_cnt) + 96'd1));
      lo_ff <= dlo[27:0];
      hi_ff <= dhi[27:0];
   end

   assign ann_ns = ann_ns_ff;
   assign sync_ns = sync_ns_ff;
   assign rcpt_base_ns = rb_ff;
   assign rcpt_ext_ns = re_ff;
   assign dreq_lo_us = lo_ff;
   assign dreq_hi_us = hi_ff;
endmodule
`default_nettype wire

### design/ptp_port_state_controller_unit.sv
// top level of the ieee 1588 port state controller
//  channel | dir | payload                         | transfer when
//  req     | in  | command, time, bmc and tx info  | req_valid & req_ready
//  rsp     | out | state, sends, sequences, wakeup | rsp_valid & rsp_ready
//  csr     | in  | register index, write data      | csr_valid & csr_ready
// one item per cycle while rsp is not stalled: input register, combinational state logic, result register
// a req transfer moves through the input register, then the result register, which raises rsp valid
// reset is synchronous active high; clears state, timers enables and counters
// a stalled rsp holds the result register and drops req_ready
`default_nettype none
module ptp_port_state_controller_unit import psc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   psc_req_if.sink req,
   psc_rsp_if.source rsp,
   psc_csr_if.sink csr
);
   cfg_type cfg_ff;
   logic [62:0] ann_ns, sync_ns, rcpt_base_ns, rcpt_ext_ns;
   logic [27:0] dlo, dhi;

   psc_intervals u_int (
      .clock(clock), .cfg(cfg_ff), .ann_ns(ann_ns), .sync_ns(sync_ns),
      .rcpt_base_ns(rcpt_base_ns), .rcpt_ext_ns(rcpt_ext_ns),
      .dreq_lo_us(dlo), .dreq_hi_us(dhi)
   );

   // configuration registers
   assign csr.ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff <= '{log_ann: 4'd1, log_sync: 4'd0, log_dreq: 4'd0, rcpt_cnt: 8'd3};
      end else if (csr.valid) begin
         case (csr.index)
            REG_LOG_ANN: cfg_ff.log_ann <= csr.wdata[3:0];
            REG_LOG_SYNC: cfg_ff.log_sync <= csr.wdata[3:0];
            REG_LOG_DREQ: cfg_ff.log_dreq <= csr.wdata[3:0];
            REG_RCPT_CNT: cfg_ff.rcpt_cnt <= csr.wdata;
            default: ;
         endcase
      end
   end

   // pipeline: input register -> state logic -> result register
   logic in_vld_ff, out_vld_ff;
   req_type in_ff;
   rsp_type out_ff;
   rsp_type rsp_in;
   logic stall;
   assign stall = out_vld_ff && !rsp.ready;
   assign req.ready = !stall;
   assign rsp.valid = out_vld_ff;
   assign rsp.data = out_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         in_vld_ff <= 1'b0;
         out_vld_ff <= 1'b0;
      end else if (!stall) begin
         in_vld_ff <= req.valid;
         out_vld_ff <= in_vld_ff;
      end
   end
   always_ff @(posedge clock) begin
      if (!stall) begin
         in_ff <= req.data;
         out_ff <= rsp_in;
      end
   end

   // block state
   logic [3:0] state_ff, state_in;
   logic pend_ff, pend_in;
   logic [3:0] en_ff, en_in;
   logic [62:0] ann_dl_ff, ann_dl_in, sync_dl_ff, sync_dl_in;
   logic [62:0] dreq_dl_ff, dreq_dl_in, rcpt_dl_ff, rcpt_dl_in;
   logic [15:0] sync_cnt_ff, sync_cnt_in, dreq_cnt_ff, dreq_cnt_in;
   logic [15:0] ann_cnt_ff, ann_cnt_in;
   logic [63:0] master_ff, master_in;

   logic [62:0] now, rcpt_new, dreq_new, m3_dl, wk;
   logic [27:0] dclamp;
   logic [95:0] m3_prod;
   logic enter, acc, recv, pass2;
   logic [3:0] s;

   always_comb begin
      now = in_ff.now_ns;
      acc = in_ff.sends_accepted;
      enter = 1'b0;
      pass2 = 1'b0;
      rcpt_new = sat_add(now, in_ff.random_extra_window ? rcpt_ext_ns : rcpt_base_ns);
      dclamp = in_ff.random_delay_us;
      if (dclamp < dlo) dclamp = dlo;
      if (dclamp > dhi) dclamp = dhi;
      dreq_new = sat_add(now, 63'(dclamp) * 63'd1000);
      m3_prod = 96'(ann_ns) * (96'(in_ff.hop_count) + 96'd1);
      m3_dl = sat_add(now, (in_ff.recommendation == REC_M3) ? sat63(m3_prod) : 63'd0);

      state_in = state_ff; pend_in = pend_ff; en_in = en_ff;
      ann_dl_in = ann_dl_ff; sync_dl_in = sync_dl_ff;
      dreq_dl_in = dreq_dl_ff; rcpt_dl_in = rcpt_dl_ff;
      sync_cnt_in = sync_cnt_ff; dreq_cnt_in = dreq_cnt_ff;
      ann_cnt_in = ann_cnt_ff; master_in = master_ff;
      rsp_in = '0;
      s = state_ff;
      recv = (s == ST_LISTENING) || (s == ST_UNCAL) || (s == ST_SLAVE);

      if (in_vld_ff) begin
         case (in_ff.command)
            CMD_TICK: begin
               // at most two handler passes: init or premaster may chain once
               for (int p = 0; p < 2; p++) begin
                  pass2 = (p == 0) || pend_in;
                  if (pass2) begin
                     enter = pend_in;
                     pend_in = 1'b0;
                     case (state_in)
                        ST_INIT: begin
                           if (enter) begin en_in[TMR_RCPT] = 1'b0; rcpt_dl_in = '0; end
                           state_in = ST_LISTENING; en_in = '0; pend_in = 1'b1;
                        end
                        ST_FAULTY, ST_DISABLED, ST_PREMASTER: begin
                           if (enter) begin en_in[TMR_RCPT] = 1'b0; rcpt_dl_in = '0; end
                           if (state_in == ST_PREMASTER && ann_dl_in <= now) begin
                              state_in = ST_MASTER; en_in = '0; pend_in = 1'b1;
                           end
                        end
                        ST_LISTENING, ST_PASSIVE: begin
                           if (enter) begin rcpt_dl_in = rcpt_new; en_in[TMR_RCPT] = 1'b1; end
                        end
                        ST_MASTER: begin
                           if (enter) begin
                              sync_cnt_in = '0; dreq_cnt_in = '0;
                              en_in[TMR_RCPT] = 1'b0; rcpt_dl_in = '0;
                           end
                           if (enter || sync_dl_in <= now) begin
                              rsp_in.send_sync = 1'b1;
                              rsp_in.message_sequence = sync_cnt_in;
                              if (acc) begin
                                 sync_cnt_in = sync_cnt_in + 16'd1;
                                 sync_dl_in = sat_add(now, sync_ns);
                                 en_in[TMR_SYNC] = 1'b1;
                              end
                           end
                           if (enter || ann_dl_in <= now) begin
                              rsp_in.send_announce = 1'b1;
                              rsp_in.announce_sequence = ann_cnt_in;
                              if (acc) begin
                                 ann_cnt_in = ann_cnt_in + 16'd1;
                                 ann_dl_in = sat_add(now, ann_ns);
                                 en_in[TMR_ANN] = 1'b1;
                              end
                           end
                        end
                        ST_UNCAL, ST_SLAVE: begin
                           if (enter) begin
                              if (state_in == ST_UNCAL) begin
                                 sync_cnt_in = '0; dreq_cnt_in = '0;
                              end
                              rcpt_dl_in = rcpt_new; en_in[TMR_RCPT] = 1'b1;
                           end
                           if ((enter && state_in == ST_UNCAL) || dreq_dl_in <= now) begin
                              rsp_in.send_delay_req = 1'b1;
                              rsp_in.message_sequence = dreq_cnt_in;
                              if (acc) begin
                                 dreq_cnt_in = dreq_cnt_in + 16'd1;
                                 dreq_dl_in = dreq_new;
                                 en_in[TMR_DREQ] = 1'b1;
                              end
                           end
                        end
                        default: ;
                     endcase
                  end
               end
            end
            CMD_BMC: begin
               if (in_ff.recommendation <= REC_M3) begin
                  if (recv || s == ST_PASSIVE) begin
                     ann_dl_in = m3_dl;
                     rsp_in.bmc_changed = 1'b1;
                     if (s != ST_PREMASTER) begin
                        state_in = ST_PREMASTER; en_in = '0; pend_in = 1'b1;
                     end
                     en_in[TMR_ANN] = 1'b1;
                  end
               end else if (in_ff.recommendation <= REC_P2) begin
                  if (s != ST_PASSIVE) master_in = in_ff.master_identity;
                  if (recv || s == ST_PREMASTER || s == ST_MASTER) begin
                     rsp_in.bmc_changed = 1'b1;
                     state_in = ST_PASSIVE; en_in = '0; pend_in = 1'b1;
                  end
               end else if (in_ff.recommendation == REC_S1) begin
                  if (s == ST_SLAVE) begin
                     if (master_ff != in_ff.master_identity) begin
                        master_in = in_ff.master_identity;
                        rsp_in.bmc_changed = 1'b1;
                        state_in = ST_UNCAL; en_in = '0; pend_in = 1'b1;
                     end
                  end else if (s == ST_LISTENING || s == ST_PREMASTER ||
                               s == ST_MASTER || s == ST_PASSIVE) begin
                     master_in = in_ff.master_identity;
                     state_in = ST_UNCAL; en_in = '0; pend_in = 1'b1;
                     rsp_in.bmc_changed = 1'b1;
                  end else if (s == ST_UNCAL) begin
                     if (master_ff != in_ff.master_identity) begin
                        master_in = in_ff.master_identity;
                        rsp_in.bmc_changed = 1'b1;
                     end
                  end
               end
            end
            CMD_CHECK: begin
               if (en_ff[TMR_RCPT] && rcpt_dl_ff <= now && (recv || s == ST_PASSIVE)) begin
                  rsp_in.receipt_expired = 1'b1;
                  en_in[TMR_RCPT] = 1'b0;
               end
            end
            default: ;
         endcase
      end

      // earliest enabled deadline, capped at now plus the wake span
      wk = sat_add(now, WAKE_SPAN_NS[62:0]);
      if (en_in[TMR_ANN] && ann_dl_in < wk) wk = ann_dl_in;
      if (en_in[TMR_SYNC] && sync_dl_in < wk) wk = sync_dl_in;
      if (en_in[TMR_DREQ] && dreq_dl_in < wk) wk = dreq_dl_in;
      if (en_in[TMR_RCPT] && rcpt_dl_in < wk) wk = rcpt_dl_in;
      rsp_in.next_wakeup_ns = wk;
      rsp_in.port_state_now = state_in;
   end

   // state advances only when the item moves into the result register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_INIT; pend_ff <= 1'b1; en_ff <= '0;
         ann_dl_ff <= '0; sync_dl_ff <= '0; dreq_dl_ff <= '0; rcpt_dl_ff <= '0;
         sync_cnt_ff <= '0; dreq_cnt_ff <= '0; ann_cnt_ff <= '0; master_ff <= '0;
      end else if (in_vld_ff && !stall) begin
         state_ff <= state_in; pend_ff <= pend_in; en_ff <= en_in;
         ann_dl_ff <= ann_dl_in; sync_dl_ff <= sync_dl_in;
         dreq_dl_ff <= dreq_dl_in; rcpt_dl_ff <= rcpt_dl_in;
         sync_cnt_ff <= sync_cnt_in; dreq_cnt_ff <= dreq_cnt_in;
         ann_cnt_ff <= ann_cnt_in; master_ff <= master_in;
      end
   end
endmodule
`default_nettype wire

### design/psc_checker.sv
// port-level checker for the port state controller, bound to the top level
`default_nettype none
`include "ptp_port_state_controller_unit_assert.svh"
module psc_checker import psc_pkg::*; (
   input wire logic clock,
   input wire logic reset,
   input wire logic rsp_valid,
   input wire logic rsp_ready,
   input wire rsp_type rsp_data
);
   `PSC_ASSERT_IMPL(a_state_range, clock, reset, rsp_valid, rsp_data.port_state_now <= ST_SLAVE)
   `PSC_ASSERT_IMPL(a_one_event, clock, reset, rsp_valid && rsp_data.bmc_changed, !rsp_data.send_sync && !rsp_data.send_delay_req && !rsp_data.receipt_expired)
   `PSC_ASSERT_IMPL(a_sync_master, clock, reset, rsp_valid && (rsp_data.send_sync || rsp_data.send_announce), rsp_data.port_state_now == ST_MASTER)
   `PSC_ASSERT_NEXT(a_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_data))
endmodule

bind ptp_port_state_controller_unit psc_checker u_chk (
   .clock(clock), .reset(reset), .rsp_valid(rsp.valid), .rsp_ready(rsp.ready),
   .rsp_data(rsp.data)
);
`default_nettype wire
